@@ sv/vfmc_pkg.sv @@
package vfmc_pkg;

	// Event codes carried on the kind field.
	typedef enum logic [2:0] {
		KIND_TICK       = 3'd0,
		KIND_PM25       = 3'd1,
		KIND_MODE_KEY   = 3'd2,
		KIND_PATH_KEY   = 3'd3,
		KIND_CLEAN_RST  = 3'd4,
		KIND_CHANGE_RST = 3'd5,
		KIND_REMOTE     = 3'd6
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_CLEAN_MONTHS  = 2'd0,
		REG_CHANGE_MONTHS = 2'd1,
		REG_PM25_LIMIT    = 2'd2
	} reg_idx_t;

	// Air path codes.
	localparam logic [1:0] PATH_OUTER  = 2'd0;
	localparam logic [1:0] PATH_INNER  = 2'd1;
	localparam logic [1:0] PATH_BYPASS = 2'd2;

	// Filter status codes.
	localparam logic [1:0] FILT_NORMAL = 2'd0;
	localparam logic [1:0] FILT_CLEAN  = 2'd1;
	localparam logic [1:0] FILT_CHANGE = 2'd2;

	// Limits of the run-time cascades and the auto timers.
	localparam logic [5:0] MINUTE_LIMIT    = 6'd60;
	localparam logic [7:0] MODE_HOUR_LIMIT = 8'd60;
	localparam logic [4:0] HOURS_LIMIT     = 5'd24;
	localparam logic [4:0] DAYS_LIMIT      = 5'd30;
	localparam logic [3:0] MONTHS_LIMIT    = 4'd12;
	localparam logic [7:0] INNER_HOLD_MIN  = 8'd30;
	localparam logic [15:0] PM_CLEAR_LEVEL = 16'd50;

	// Reset values.
	localparam logic [3:0] CLEAN_MONTHS_RST  = 4'd3;
	localparam logic [3:0] CHANGE_MONTHS_RST = 4'd6;
	localparam logic [7:0] PM25_LIMIT_RST    = 8'd75;
	localparam logic [15:0] PM25_RST         = 16'd6;

	typedef struct packed {
		logic [3:0] clean_months;
		logic [3:0] change_months;
		logic [7:0] pm25_limit;
	} cfg_t;

	typedef struct packed {
		logic [5:0]  prescaler;
		logic [4:0]  clean_hours;
		logic [4:0]  clean_days;
		logic [3:0]  clean_months_count;
		logic [4:0]  change_hours;
		logic [4:0]  change_days;
		logic [3:0]  change_months_count;
		logic [1:0]  filter_state;
		logic [1:0]  path_state;
		logic        auto_state;
		logic        timer_en;
		logic [7:0]  mode_minutes;
		logic [15:0] latest_pm25;
	} state_t;

endpackage

@@ sv/vfmc_core.sv @@
module vfmc_core (
	input  vfmc_pkg::state_t st,
	input  vfmc_pkg::cfg_t   cfg,
	input  logic [2:0]       kind,
	input  logic [15:0]      value,
	output vfmc_pkg::state_t ns,
	output logic             report
);
	import vfmc_pkg::*;

	// Advance the hour, day and month counters of one cascade by an hour.
	function automatic logic [13:0] cascade_hour(input logic [4:0] h, input logic [4:0] d,
		input logic [3:0] m);
		logic [4:0] nh;
		logic [4:0] nd;
		logic [3:0] nm;
		nh = h + 5'd1;
		nd = d;
		nm = m;
		if (nh > HOURS_LIMIT) begin
			nh = '0;
			nd = d + 5'd1;
			if (nd > DAYS_LIMIT) begin
				nd = '0;
				nm = m + 4'd1;
				if (nm > MONTHS_LIMIT) begin
					nm = '0;
				end
			end
		end
		return {nh, nd, nm};
	endfunction

	always_comb begin
		ns = st;
		report = 1'b0;

		// Event handling.
		case (kind)
			KIND_TICK: begin
				ns.prescaler = st.prescaler + 6'd1;
				ns.mode_minutes = st.mode_minutes + 8'd1;
			end
			KIND_PM25: begin
				ns.latest_pm25 = value;
			end
			KIND_MODE_KEY: begin
				ns.auto_state = ~st.auto_state;
				ns.mode_minutes = '0;
				ns.timer_en = ~st.auto_state;
				report = 1'b1;
			end
			KIND_PATH_KEY: begin
				ns.path_state = (st.path_state >= PATH_BYPASS) ? PATH_OUTER
					: st.path_state + 2'd1;
				report = 1'b1;
			end
			KIND_CLEAN_RST: begin
				if (st.filter_state == FILT_CLEAN) begin
					ns.clean_hours = '0;
					ns.clean_days = '0;
					ns.clean_months_count = '0;
					ns.filter_state = FILT_NORMAL;
					report = 1'b1;
				end
			end
			KIND_CHANGE_RST: begin
				if (st.filter_state == FILT_CHANGE) begin
					ns.change_hours = '0;
					ns.change_days = '0;
					ns.change_months_count = '0;
					ns.filter_state = FILT_NORMAL;
					report = 1'b1;
				end
			end
			KIND_REMOTE: begin
				ns.path_state = (value > 16'(PATH_BYPASS)) ? PATH_BYPASS : value[1:0];
			end
			default: begin
			end
		endcase

		// Hourly step of both filter cascades and the status update.
		if (ns.prescaler > MINUTE_LIMIT) begin
			ns.prescaler = '0;
			{ns.clean_hours, ns.clean_days, ns.clean_months_count} =
				cascade_hour(ns.clean_hours, ns.clean_days, ns.clean_months_count);
			{ns.change_hours, ns.change_days, ns.change_months_count} =
				cascade_hour(ns.change_hours, ns.change_days, ns.change_months_count);
			if (ns.change_months_count > cfg.change_months) begin
				ns.filter_state = FILT_CHANGE;
			end
			if (ns.clean_months_count > cfg.clean_months && ns.filter_state != FILT_CHANGE) begin
				ns.filter_state = FILT_CLEAN;
			end
			report = 1'b1;
		end

		// Automatic air path selection.
		if (ns.auto_state) begin
			if (ns.path_state == PATH_INNER && ns.mode_minutes > INNER_HOLD_MIN && ns.timer_en) begin
				ns.path_state = PATH_OUTER;
				ns.mode_minutes = '0;
				report = 1'b1;
			end
			if ((ns.path_state == PATH_OUTER || ns.path_state == PATH_BYPASS)
				&& ns.mode_minutes > MODE_HOUR_LIMIT) begin
				ns.mode_minutes = '0;
				if (ns.latest_pm25 > {8'd0, cfg.pm25_limit}) begin
					ns.path_state = PATH_INNER;
					ns.timer_en = 1'b0;
					report = 1'b1;
				end else begin
					ns.timer_en = 1'b1;
				end
			end
			if (ns.path_state == PATH_INNER && ns.latest_pm25 < PM_CLEAR_LEVEL) begin
				ns.timer_en = 1'b1;
			end
		end
	end

endmodule

@@ sv/ventilation_filter_and_mode_controller_top.sv @@
// A result beat appears in the cycle after its input beat is accepted.
// One item per cycle while the receiver takes results; the whole update is one
// combinational pass from the state register, which also holds the results, back into it.
// Reset (arst_n low, asynchronous): counters clear, status normal, outer air,
// automatic mode, PM2.5 reading 6, registers to 3, 6 and 75 months/level.
module ventilation_filter_and_mode_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  air_path,
	output logic        auto_mode,
	output logic [1:0]  filter_status,
	output logic        status_report,
	output logic [3:0]  clean_months_run,
	output logic [3:0]  change_months_run,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import vfmc_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_next;
	logic   report_next;
	logic   report_q;
	logic   accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clean_months <= CLEAN_MONTHS_RST;
			cfg_q.change_months <= CHANGE_MONTHS_RST;
			cfg_q.pm25_limit <= PM25_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLEAN_MONTHS:  cfg_q.clean_months <= cfg_data[3:0];
				REG_CHANGE_MONTHS: cfg_q.change_months <= cfg_data[3:0];
				REG_PM25_LIMIT:    cfg_q.pm25_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Next state for one event.
	vfmc_core u_core (
		.st     (state_q),
		.cfg    (cfg_q),
		.kind   (kind),
		.value  (value),
		.ns     (state_next),
		.report (report_next)
	);

	// A new beat enters whenever the result register is empty or being drained.
	assign in_ready = !out_valid || out_ready;
	assign accept = in_valid && in_ready;

	// State register; it also holds the result fields of the last item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				prescaler: '0, clean_hours: '0, clean_days: '0, clean_months_count: '0,
				change_hours: '0, change_days: '0, change_months_count: '0,
				filter_state: FILT_NORMAL, path_state: PATH_OUTER, auto_state: 1'b1,
				timer_en: 1'b0, mode_minutes: '0, latest_pm25: PM25_RST};
			out_valid <= 1'b0;
		end else if (accept) begin
			state_q <= state_next;
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Report flag of the pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			report_q <= report_next;
		end
	end

	assign air_path = state_q.path_state;
	assign auto_mode = state_q.auto_state;
	assign filter_status = state_q.filter_state;
	assign status_report = report_q;
	assign clean_months_run = state_q.clean_months_count;
	assign change_months_run = state_q.change_months_count;

endmodule

@@ test/ventilation_filter_and_mode_controller_top_tb.sv @@
`timescale 1ns / 100ps

module ventilation_filter_and_mode_controller_top_tb;

	import vfmc_pkg::*;

	// Event code that the block has no use for; it must only settle the auto logic.
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	// Index with no register behind it.
	localparam logic [1:0] SPARE_REG_INDEX = 2'd3;

	// Timing limits of the prediction, kept apart from the package on purpose.
	localparam logic [5:0] HOUR_MINUTES   = 6'd60;
	localparam logic [4:0] DAY_HOURS      = 5'd24;
	localparam logic [4:0] MONTH_DAYS     = 5'd30;
	localparam logic [3:0] YEAR_MONTHS    = 4'd12;
	localparam logic [7:0] AUTO_HOUR_MIN  = 8'd60;
	localparam logic [7:0] INNER_HOLD     = 8'd30;
	localparam logic [15:0] CLEAR_AIR_PM  = 16'd50;

	localparam int QUIET_LIMIT    = 5000;
	localparam int RX_HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0] air_path;
		logic       auto_mode;
		logic [1:0] filter_status;
		logic       status_report;
		logic [3:0] clean_run;
		logic [3:0] change_run;
	} panel_state_t;

	// Tracks the controller state, predicts the panel state after each event beat
	// and checks the result beats in order.
	class vent_scoreboard;
		logic [3:0]  clean_lim;
		logic [3:0]  change_lim;
		logic [7:0]  pm_lim;

		logic [5:0]  prescaler;
		logic [4:0]  cl_hours, cl_days;
		logic [3:0]  cl_months;
		logic [4:0]  ch_hours, ch_days;
		logic [3:0]  ch_months;
		logic [1:0]  filt;
		logic [1:0]  path;
		logic        auto_on;
		logic        timer_en;
		logic [7:0]  mode_min;
		logic [15:0] pm;

		int failures;
		int events_noted;
		int results_checked;
		int reports_expected;
		int hour_steps;
		int inner_switches;

		panel_state_t expected_panel[$];

		function new();
			clean_lim = 4'd3;
			change_lim = 4'd6;
			pm_lim = 8'd75;
			prescaler = '0;
			cl_hours = '0;
			cl_days = '0;
			cl_months = '0;
			ch_hours = '0;
			ch_days = '0;
			ch_months = '0;
			filt = FILT_NORMAL;
			path = PATH_OUTER;
			auto_on = 1'b1;
			timer_en = 1'b0;
			mode_min = '0;
			pm = 16'd6;
		endfunction

		function void set_register(logic [1:0] idx, logic [7:0] data);
			case (idx)
				REG_CLEAN_MONTHS:  clean_lim = data[3:0];
				REG_CHANGE_MONTHS: change_lim = data[3:0];
				REG_PM25_LIMIT:    pm_lim = data;
				default: ;
			endcase
		endfunction

		// One hour into a run-time cascade; the month count wraps past twelve.
		function void bump_cascade(inout logic [4:0] h, inout logic [4:0] d, inout logic [3:0] m);
			h = h + 5'd1;
			if (h > DAY_HOURS) begin
				h = '0;
				d = d + 5'd1;
				if (d > MONTH_DAYS) begin
					d = '0;
					m = m + 4'd1;
					if (m > YEAR_MONTHS)
						m = '0;
				end
			end
		endfunction

		// Advances the state by one event and queues the panel state it leads to.
		function void note_event(logic [2:0] k, logic [15:0] v);
			panel_state_t p;
			logic rep;
			rep = 1'b0;
			events_noted++;

			case (k)
				KIND_TICK: begin
					prescaler = prescaler + 6'd1;
					mode_min = mode_min + 8'd1;
				end
				KIND_PM25: pm = v;
				KIND_MODE_KEY: begin
					auto_on = !auto_on;
					mode_min = '0;
					timer_en = auto_on;
					rep = 1'b1;
				end
				KIND_PATH_KEY: begin
					path = (path >= PATH_BYPASS) ? PATH_OUTER : path + 2'd1;
					rep = 1'b1;
				end
				KIND_CLEAN_RST: begin
					if (filt == FILT_CLEAN) begin
						cl_hours = '0;
						cl_days = '0;
						cl_months = '0;
						filt = FILT_NORMAL;
						rep = 1'b1;
					end
				end
				KIND_CHANGE_RST: begin
					if (filt == FILT_CHANGE) begin
						ch_hours = '0;
						ch_days = '0;
						ch_months = '0;
						filt = FILT_NORMAL;
						rep = 1'b1;
					end
				end
				KIND_REMOTE: path = (v > 16'(PATH_BYPASS)) ? PATH_BYPASS : v[1:0];
				default: ;
			endcase

			// Hour step: both cascades age, change due wins over clean due.
			if (prescaler > HOUR_MINUTES) begin
				prescaler = '0;
				hour_steps++;
				bump_cascade(cl_hours, cl_days, cl_months);
				bump_cascade(ch_hours, ch_days, ch_months);
				if (ch_months > change_lim)
					filt = FILT_CHANGE;
				if (cl_months > clean_lim && filt != FILT_CHANGE)
					filt = FILT_CLEAN;
				rep = 1'b1;
			end

			// Automatic air path, settled within the same event.
			if (auto_on) begin
				if (path == PATH_INNER && mode_min > INNER_HOLD && timer_en) begin
					path = PATH_OUTER;
					mode_min = '0;
					rep = 1'b1;
				end
				if ((path == PATH_OUTER || path == PATH_BYPASS) && mode_min > AUTO_HOUR_MIN) begin
					mode_min = '0;
					if (pm > {8'd0, pm_lim}) begin
						path = PATH_INNER;
						timer_en = 1'b0;
						rep = 1'b1;
						inner_switches++;
					end else begin
						timer_en = 1'b1;
					end
				end
				if (path == PATH_INNER && pm < CLEAR_AIR_PM)
					timer_en = 1'b1;
			end

			if (rep)
				reports_expected++;
			p.air_path = path;
			p.auto_mode = auto_on;
			p.filter_status = filt;
			p.status_report = rep;
			p.clean_run = cl_months;
			p.change_run = ch_months;
			expected_panel.push_back(p);
		endfunction

		function void report_failure(string msg);
			failures++;
			$error("%s", msg);
		endfunction

		function void compare(string field, logic [3:0] want, logic [3:0] got);
			if (want !== got)
				report_failure($sformatf("%s: expected %0d, got %0d", field, want, got));
		endfunction

		function void check_panel(panel_state_t got);
			panel_state_t want;
			results_checked++;
			if (expected_panel.size() == 0) begin
				report_failure("result beat arrived with no event beat waiting");
				return;
			end
			want = expected_panel.pop_front();
			compare("air_path", want.air_path, got.air_path);
			compare("auto_mode", want.auto_mode, got.auto_mode);
			compare("filter_status", want.filter_status, got.filter_status);
			compare("status_report", want.status_report, got.status_report);
			compare("clean_months_run", want.clean_run, got.clean_run);
			compare("change_months_run", want.change_run, got.change_run);
		endfunction

		function int pending_count();
			return expected_panel.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = '0;
	logic [15:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  air_path;
	logic        auto_mode;
	logic [1:0]  filter_status;
	logic        status_report;
	logic [3:0]  clean_months_run;
	logic [3:0]  change_months_run;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	vent_scoreboard sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit rx_hold = 1'b0;
	bit hold_request = 1'b0;
	int quiet_cycles = 0;

	ventilation_filter_and_mode_controller_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.air_path(air_path),
		.auto_mode(auto_mode),
		.filter_status(filter_status),
		.status_report(status_report),
		.clean_months_run(clean_months_run),
		.change_months_run(change_months_run),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin : long_backpressure
		wait (hold_request);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// Monitor: result beats are checked before the event beat of the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_panel({air_path, auto_mode, filter_status, status_report,
					clean_months_run, change_months_run});
			if (in_valid && in_ready)
				sb.note_event(kind, value);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin : watchdog
		do @(negedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("Timed out with no beat moving for %0d cycles.", QUIET_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// Offers one event beat, with random gaps, and returns at the falling edge after it is taken.
	task automatic send_beat(logic [2:0] k, logic [15:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Waits until every expected result beat has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_count() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic put_reg(logic [1:0] idx, logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_register(idx, data);
		@(negedge clk);
	endtask

	// Writes all three registers; unused upper bits of the month limits carry noise.
	task automatic write_settings(logic [3:0] clean_m, logic [3:0] change_m, logic [7:0] pm_l,
			bit poke_spare);
		put_reg(REG_CLEAN_MONTHS, {4'($urandom_range(15)), clean_m});
		put_reg(REG_CHANGE_MONTHS, {4'($urandom_range(15)), change_m});
		put_reg(REG_PM25_LIMIT, pm_l);
		if (poke_spare)
			put_reg(SPARE_REG_INDEX, 8'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Mostly minute ticks and sensor samples, with keys, resets, remote sets and unused codes mixed in.
	task automatic random_events(int count);
		logic [2:0] k;
		logic [15:0] v;
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			v = 16'($urandom);
			if (pick < 70) begin
				k = KIND_TICK;
			end else if (pick < 84) begin
				k = KIND_PM25;
				if ($urandom_range(4) != 0)
					v = 16'($urandom_range(200));
			end else if (pick < 87) begin
				k = KIND_MODE_KEY;
			end else if (pick < 90) begin
				k = KIND_PATH_KEY;
			end else if (pick < 92) begin
				k = KIND_CLEAN_RST;
			end else if (pick < 94) begin
				k = KIND_CHANGE_RST;
			end else if (pick < 98) begin
				k = KIND_REMOTE;
				if ($urandom_range(3) != 0)
					v = 16'($urandom_range(3));
			end else begin
				k = KIND_UNUSED;
			end
			send_beat(k, v);
		end
	endtask

	initial begin : stimulus
		sb = new();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed events at reset settings.
		tx_idle_pct = 20;
		rx_idle_pct = 75;
		send_beat(KIND_TICK, 16'hFFFF);
		send_beat(KIND_PM25, 16'hFFFF);
		send_beat(KIND_PM25, 16'h0000);
		send_beat(KIND_PM25, 16'd49);
		send_beat(KIND_PM25, 16'd50);
		send_beat(KIND_REMOTE, 16'hFFFF);
		send_beat(KIND_REMOTE, 16'd3);
		send_beat(KIND_REMOTE, 16'd2);
		send_beat(KIND_REMOTE, 16'd1);
		send_beat(KIND_REMOTE, 16'd0);
		send_beat(KIND_PATH_KEY, 16'h5555);
		send_beat(KIND_PATH_KEY, 16'hAAAA);
		send_beat(KIND_PATH_KEY, 16'h0000);
		send_beat(KIND_MODE_KEY, 16'h0F0F);
		send_beat(KIND_MODE_KEY, 16'hF0F0);
		send_beat(KIND_CLEAN_RST, 16'hFFFF);
		send_beat(KIND_CHANGE_RST, 16'h0000);
		send_beat(KIND_UNUSED, 16'hFFFF);
		send_beat(KIND_PM25, 16'd76);
		send_beat(KIND_PM25, 16'd75);

		settle();
		write_settings(4'd1, 4'd12, 8'd30, 1'b0);
		random_events(140);

		settle();
		tx_idle_pct = 75;
		rx_idle_pct = 20;
		write_settings(4'd12, 4'd1, 8'd150, 1'b0);
		random_events(140);

		// No idling; the receiver holds off for a long stretch partway through.
		settle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_settings(4'd0, 4'd14, 8'd255, 1'b1);
		random_events(40);
		hold_request = 1'b1;
		random_events(100);

		// Lowest month limits with a final burst of mixed events.
		settle();
		write_settings(4'd0, 4'd0, 8'd75, 1'b0);
		random_events(20);

		settle();
		$display("Covered %0d event beats, %0d result beats, %0d hour steps, %0d status reports.",
			sb.events_noted, sb.results_checked, sb.hour_steps, sb.reports_expected);
		$display("Mixed events ran under three stall patterns; auto mode chose inner air %0d times.",
			sb.inner_switches);
		if (sb.failures == 0 && sb.pending_count() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
